[hdl/rsd_pkg.sv]
// Shared types and constants for the run-length sprite decoder.
// Used by rle_sprite_decoder_top; depends on nothing else.
package rsd_pkg;

	// Default sizing.
	localparam int MAX_DIM       = 255;
	localparam int PALETTE_DEPTH = 256;

	// Record layout.
	localparam int HDR_BYTES   = 8;
	localparam int LEN_W       = 20;
	localparam logic [LEN_W-1:0] MIN_RECORD = LEN_W'(HDR_BYTES);

	// Parser phases.
	typedef enum logic [2:0] {
		PH_HEADER,
		PH_ROWCNT,
		PH_SKIP,
		PH_SOLID,
		PH_PIXEL,
		PH_DRAIN,
		PH_REJECT
	} phase_t;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_HEADER,
		KIND_PIXEL,
		KIND_DONE,
		KIND_REJECT
	} kind_t;

	// Input operations.
	typedef enum logic {
		OP_PALETTE,
		OP_SPRITE
	} op_t;

	// One input beat.
	typedef struct packed {
		op_t        op;
		logic [7:0] sprite_byte;
		logic [7:0] pal_addr;
		logic [7:0] pal_red;
		logic [7:0] pal_green;
		logic [7:0] pal_blue;
	} in_t;

	// One result beat.
	typedef struct packed {
		kind_t              kind;
		logic [7:0]         pos_x;
		logic [7:0]         pos_y;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         width;
		logic [7:0]         height;
		logic signed [15:0] x_offset;
		logic signed [15:0] y_offset;
	} out_t;

endpackage

[hdl/rle_sprite_decoder_top.sv]
// Run-length transparent sprite decoder, top level.
// Depends on rsd_pkg for the beat types, phases and result kinds.

// The decoder takes one beat per cycle: a palette write or one byte of a sprite
// record. Each record byte steps a small parser and, for a pixel byte, reads the
// palette; the registered palette read and the parser outputs meet in one stage
// register, which feeds a result register. A byte that gives one result or none
// is taken every cycle unless the output stalls. A byte that ends a record with
// a pixel, or a last header byte that is not rejected and ends a record, gives
// two results; the input then stalls until the single result register has
// taken the first. A stalled output stalls the input once the stage register
// holds results. Palette entries read before they are written give unspecified
// colours. The record length register applies at once; the user must write it
// only while the decoder is idle, which the block itself does not enforce.
module rle_sprite_decoder_top #(
	parameter int MAX_DIM       = rsd_pkg::MAX_DIM,
	parameter int PALETTE_DEPTH = rsd_pkg::PALETTE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  rsd_pkg::in_t               in_item,
	output logic                       out_valid,
	input  logic                       out_stall,
	output rsd_pkg::out_t              out_item,
	input  logic                       cfg_we,
	input  logic [rsd_pkg::LEN_W-1:0]  cfg_wdata
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int SUM_W  = ((DIM_W > 8) ? DIM_W : 8) + 1;
	localparam int PAL_AW = $clog2(PALETTE_DEPTH);
	localparam int LEN_W  = rsd_pkg::LEN_W;

	// Configuration and parser state.
	logic [LEN_W-1:0]  len_q;
	rsd_pkg::phase_t   ph_q, ph_n;
	logic [55:0]       hdr_q, hdr_n;
	logic [2:0]        hcnt_q, hcnt_n;
	logic [LEN_W-1:0]  rec_q, rec_n;
	logic [DIM_W-1:0]  row_q, row_n;
	logic [7:0]        left_q, left_n;
	logic [DIM_W-1:0]  col_q, col_n;
	logic [7:0]        run_q, run_n;
	logic [DIM_W-1:0]  sw_q, sw_n;
	logic [DIM_W-1:0]  sh_q, sh_n;

	// Stage register holding the results of one byte.
	logic [1:0]        cnt_s1;
	rsd_pkg::out_t     res0_s1, res1_s1;
	logic              pix_ok_s1;
	logic [23:0]       pal_s1;

	// Result register.
	logic              out_valid_s2;
	rsd_pkg::out_t     out_item_s2;

	// Palette memory.
	logic [23:0]       pal_mem [PALETTE_DEPTH];

	// Handshake and parse signals.
	logic              in_acc, parse_go, pal_go, out_free, move;
	logic [7:0]        b;
	logic [LEN_W-1:0]  len_eff, rec_inc;
	logic [63:0]       hdr_full;
	logic [15:0]       w16, h16;
	logic              bad, end_row, pix_emit, pix_ok;
	logic [SUM_W-1:0]  skip_sum;
	logic [1:0]        n_res;
	rsd_pkg::out_t     r0, r1, head;

	// Beat handshakes.
	assign out_free = !out_valid_s2 || !out_stall;
	assign move     = (cnt_s1 != 2'd0) && out_free;
	assign in_stall = !((cnt_s1 == 2'd0) || ((cnt_s1 == 2'd1) && out_free));
	assign in_acc   = in_valid && !in_stall;
	assign parse_go = in_acc && (in_item.op == rsd_pkg::OP_SPRITE);
	assign pal_go   = in_acc && (in_item.op == rsd_pkg::OP_PALETTE)
		&& (9'(in_item.pal_addr) < 9'(PALETTE_DEPTH));
	assign b        = in_item.sprite_byte;
	assign pix_ok   = 9'(b) < 9'(PALETTE_DEPTH);

	// Lengths below the header size count as the header size.
	assign len_eff  = (len_q < rsd_pkg::MIN_RECORD) ? rsd_pkg::MIN_RECORD : len_q;
	assign rec_inc  = rec_q + LEN_W'(1);

	// Header fields, with the incoming byte as the top byte.
	assign hdr_full = {b, hdr_q};
	assign w16      = hdr_full[15:0];
	assign h16      = hdr_full[31:16];
	assign bad      = w16[15] || h16[15] || (w16 > 16'(MAX_DIM)) || (h16 > 16'(MAX_DIM));
	assign skip_sum = SUM_W'(col_q) + SUM_W'(b);

	// Parser next state and the results of this byte.
	always_comb begin
		ph_n     = ph_q;
		hdr_n    = hdr_q;
		hcnt_n   = hcnt_q;
		rec_n    = rec_q;
		row_n    = row_q;
		left_n   = left_q;
		col_n    = col_q;
		run_n    = run_q;
		sw_n     = sw_q;
		sh_n     = sh_q;
		r0       = '0;
		r1       = '0;
		n_res    = 2'd0;
		end_row  = 1'b0;
		pix_emit = 1'b0;
		if (ph_q == rsd_pkg::PH_HEADER) begin
			rec_n  = rec_inc;
			hdr_n  = {b, hdr_q[55:8]};
			hcnt_n = hcnt_q + 3'd1;
			if (hcnt_q == 3'(rsd_pkg::HDR_BYTES - 1)) begin
				hdr_n  = '0;
				hcnt_n = '0;
				row_n  = '0;
				col_n  = '0;
				run_n  = '0;
				left_n = '0;
				n_res  = 2'd1;
				if (bad) begin
					r0.kind = rsd_pkg::KIND_REJECT;
					ph_n    = rsd_pkg::PH_REJECT;
				end else begin
					sw_n       = DIM_W'(w16);
					sh_n       = DIM_W'(h16);
					r0.kind    = rsd_pkg::KIND_HEADER;
					r0.width   = w16[7:0];
					r0.height  = h16[7:0];
					r0.x_offset = hdr_full[47:32];
					r0.y_offset = hdr_full[63:48];
					ph_n = (h16 == 16'd0) ? rsd_pkg::PH_DRAIN : rsd_pkg::PH_ROWCNT;
				end
				// A record that is only a header ends here.
				if (rec_inc >= len_eff) begin
					if (ph_n != rsd_pkg::PH_REJECT) begin
						r1.kind = rsd_pkg::KIND_DONE;
						n_res   = 2'd2;
					end
					ph_n  = rsd_pkg::PH_HEADER;
					rec_n = '0;
				end
			end
		end else begin
			case (ph_q)
				rsd_pkg::PH_ROWCNT: begin
					col_n  = '0;
					run_n  = '0;
					left_n = b;
					if (b == 8'd0) begin
						end_row = 1'b1;
					end else begin
						ph_n = rsd_pkg::PH_SKIP;
					end
				end
				rsd_pkg::PH_SKIP: begin
					col_n = (skip_sum > SUM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(skip_sum);
					ph_n  = rsd_pkg::PH_SOLID;
				end
				rsd_pkg::PH_SOLID: begin
					run_n = b;
					ph_n  = (b == 8'd0) ? rsd_pkg::PH_SKIP : rsd_pkg::PH_PIXEL;
				end
				rsd_pkg::PH_PIXEL: begin
					if (col_q < sw_q) begin
						pix_emit = 1'b1;
						r0.kind  = rsd_pkg::KIND_PIXEL;
						r0.pos_x = 8'(col_q);
						r0.pos_y = 8'(row_q);
						n_res    = 2'd1;
					end
					if (col_q < DIM_W'(MAX_DIM)) begin
						col_n = col_q + DIM_W'(1);
					end
					run_n = run_q - 8'd1;
					if (run_q == 8'd1) begin
						ph_n = rsd_pkg::PH_SKIP;
					end
				end
				default: begin
				end
			endcase
			// Every byte inside a row counts down the row.
			if (ph_q inside {rsd_pkg::PH_SKIP, rsd_pkg::PH_SOLID, rsd_pkg::PH_PIXEL}) begin
				left_n = left_q - 8'd1;
				if (left_q == 8'd1) begin
					end_row = 1'b1;
				end
			end
			if (end_row) begin
				row_n = row_q + DIM_W'(1);
				ph_n  = (row_n >= sh_q) ? rsd_pkg::PH_DRAIN : rsd_pkg::PH_ROWCNT;
			end
			// Record end; done follows any pixel of the same byte.
			rec_n = rec_inc;
			if (rec_inc >= len_eff) begin
				if (ph_n != rsd_pkg::PH_REJECT) begin
					if (pix_emit) begin
						r1.kind = rsd_pkg::KIND_DONE;
						n_res   = 2'd2;
					end else begin
						r0.kind = rsd_pkg::KIND_DONE;
						n_res   = 2'd1;
					end
				end
				ph_n  = rsd_pkg::PH_HEADER;
				rec_n = '0;
			end
		end
	end

	// Configuration register and parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= rsd_pkg::MIN_RECORD;
			ph_q   <= rsd_pkg::PH_HEADER;
			hdr_q  <= '0;
			hcnt_q <= '0;
			rec_q  <= '0;
			row_q  <= '0;
			left_q <= '0;
			col_q  <= '0;
			run_q  <= '0;
			sw_q   <= '0;
			sh_q   <= '0;
		end else begin
			if (cfg_we) begin
				len_q <= cfg_wdata;
			end
			if (parse_go) begin
				ph_q   <= ph_n;
				hdr_q  <= hdr_n;
				hcnt_q <= hcnt_n;
				rec_q  <= rec_n;
				row_q  <= row_n;
				left_q <= left_n;
				col_q  <= col_n;
				run_q  <= run_n;
				sw_q   <= sw_n;
				sh_q   <= sh_n;
			end
		end
	end

	// Palette write, and the registered read for a pixel byte.
	always_ff @(posedge clk) begin
		if (pal_go) begin
			pal_mem[in_item.pal_addr[PAL_AW-1:0]] <=
				{in_item.pal_red, in_item.pal_green, in_item.pal_blue};
		end
		if (parse_go) begin
			pal_s1 <= pal_mem[b[PAL_AW-1:0]];
		end
	end

	// Stage register: loads a new byte's results, or shifts as one leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1 <= 2'd0;
		end else if (parse_go) begin
			cnt_s1 <= n_res;
		end else if (move) begin
			cnt_s1 <= cnt_s1 - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (parse_go) begin
			res0_s1   <= r0;
			res1_s1   <= r1;
			pix_ok_s1 <= pix_ok;
		end else if (move) begin
			res0_s1 <= res1_s1;
		end
	end

	// Head result with its colour; an index beyond the palette gives black.
	always_comb begin
		head = res0_s1;
		if ((res0_s1.kind == rsd_pkg::KIND_PIXEL) && pix_ok_s1) begin
			head.red   = {pal_s1[21:16], 2'b00};
			head.green = {pal_s1[13:8], 2'b00};
			head.blue  = {pal_s1[5:0], 2'b00};
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (out_free) begin
			out_valid_s2 <= move;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_item_s2 <= head;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_item  = out_item_s2;

endmodule

[tb/sv/sprite_decode_checker.sv]
`timescale 1ns / 1ps
// Checker for the run-length sprite decoder. It watches the palette/byte and result channels,
// decodes every accepted beat on its own and compares the result beats in order.
// Depends on rsd_pkg for the beat types, phases and result kinds.
module sprite_decode_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  rsd_pkg::in_t               in_item,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  rsd_pkg::out_t              out_item,
	input  logic                       cfg_we,
	input  logic [rsd_pkg::LEN_W-1:0]  cfg_wdata,
	output int                         outstanding,
	output int                         mismatches
);

	localparam int LEN_W = rsd_pkg::LEN_W;

	// Decoder state as seen from outside.
	logic [LEN_W-1:0]  record_len;
	logic [23:0]       palette [rsd_pkg::PALETTE_DEPTH];
	rsd_pkg::phase_t   phase;
	logic [63:0]       hdr_shift;
	int                hdr_count;
	int                rec_count;
	int                row_idx;
	int                row_left;
	int                column;
	int                run_left;
	int                spr_w;
	int                spr_h;
	rsd_pkg::out_t     decoded_q [$];
	int                errors = 0;

	assign mismatches = errors;

	// Builds one result beat; unused fields zero; each channel is 4x the entry's low six bits.
	function automatic rsd_pkg::out_t make_result(rsd_pkg::kind_t k, int x, int y,
			logic [23:0] rgb, int w, int h, logic [15:0] xo, logic [15:0] yo);
		rsd_pkg::out_t r;
		r = '0;
		r.kind = k;
		r.pos_x = 8'(x);
		r.pos_y = 8'(y);
		r.red = {rgb[21:16], 2'b00};
		r.green = {rgb[13:8], 2'b00};
		r.blue = {rgb[5:0], 2'b00};
		r.width = 8'(w);
		r.height = 8'(h);
		r.x_offset = xo;
		r.y_offset = yo;
		return r;
	endfunction

	// Appends one expected result beat behind the ones still waiting.
	function automatic void queue_result(rsd_pkg::out_t r);
		decoded_q.insert(decoded_q.size(), r);
	endfunction

	// A finished row moves on to the next row count, or to draining after the last row.
	function automatic void end_row();
		row_idx++;
		phase = (row_idx >= spr_h) ? rsd_pkg::PH_DRAIN : rsd_pkg::PH_ROWCNT;
	endfunction

	// Steps the parser by one accepted beat and queues the results it causes.
	function automatic void decode_step(rsd_pkg::in_t b);
		logic [7:0] v;
		int         w;
		int         h;
		int         len;
		v = b.sprite_byte;
		if (b.op == rsd_pkg::OP_PALETTE) begin
			palette[b.pal_addr] = {b.pal_red, b.pal_green, b.pal_blue};
			return;
		end
		if (phase == rsd_pkg::PH_HEADER) begin
			hdr_shift[8*hdr_count +: 8] = v;
			hdr_count++;
			rec_count++;
			if (hdr_count < rsd_pkg::HDR_BYTES)
				return;
			w = int'($signed(hdr_shift[15:0]));
			h = int'($signed(hdr_shift[31:16]));
			hdr_count = 0;
			row_idx = 0;
			column = 0;
			run_left = 0;
			row_left = 0;
			if (w < 0 || h < 0 || w > rsd_pkg::MAX_DIM || h > rsd_pkg::MAX_DIM) begin
				queue_result(make_result(rsd_pkg::KIND_REJECT, 0, 0, '0, 0, 0, '0, '0));
				phase = rsd_pkg::PH_REJECT;
			end else begin
				spr_w = w;
				spr_h = h;
				queue_result(make_result(rsd_pkg::KIND_HEADER, 0, 0, '0, w, h,
					hdr_shift[47:32], hdr_shift[63:48]));
				phase = (h == 0) ? rsd_pkg::PH_DRAIN : rsd_pkg::PH_ROWCNT;
			end
			hdr_shift = '0;
		end else begin
			case (phase)
				rsd_pkg::PH_ROWCNT: begin
					column = 0;
					run_left = 0;
					row_left = v;
					if (v == 0)
						end_row();
					else
						phase = rsd_pkg::PH_SKIP;
				end
				rsd_pkg::PH_SKIP, rsd_pkg::PH_SOLID, rsd_pkg::PH_PIXEL: begin
					if (phase == rsd_pkg::PH_SKIP) begin
						column = column + v;
						if (column > rsd_pkg::MAX_DIM)
							column = rsd_pkg::MAX_DIM;
						phase = rsd_pkg::PH_SOLID;
					end else if (phase == rsd_pkg::PH_SOLID) begin
						run_left = v;
						phase = (v == 0) ? rsd_pkg::PH_SKIP : rsd_pkg::PH_PIXEL;
					end else begin
						// Pixels past the width are consumed without a result.
						if (column < spr_w)
							queue_result(make_result(rsd_pkg::KIND_PIXEL, column, row_idx,
								(v < rsd_pkg::PALETTE_DEPTH) ? palette[v] : 24'h0,
								0, 0, '0, '0));
						if (column < rsd_pkg::MAX_DIM)
							column++;
						run_left--;
						if (run_left == 0)
							phase = rsd_pkg::PH_SKIP;
					end
					row_left--;
					if (row_left == 0)
						end_row();
				end
				default: begin
				end
			endcase
			rec_count++;
		end

		// The record closes once its length is reached; short lengths count as the header size.
		len = (record_len < rsd_pkg::MIN_RECORD) ? rsd_pkg::HDR_BYTES : int'(record_len);
		if (rec_count >= len) begin
			if (phase != rsd_pkg::PH_REJECT)
				queue_result(make_result(rsd_pkg::KIND_DONE, 0, 0, '0, 0, 0, '0, '0));
			phase = rsd_pkg::PH_HEADER;
			rec_count = 0;
		end
	endfunction

	function automatic void field_check(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0d ns: %s expected 0x%h, got 0x%h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Compares one result beat with the oldest decoded one.
	function automatic void compare_result(rsd_pkg::out_t got);
		rsd_pkg::out_t want;
		if (decoded_q.size() == 0) begin
			$display("%0d ns: result beat expected none, got kind %0d x %0d y %0d", $time,
				got.kind, got.pos_x, got.pos_y);
			errors++;
			return;
		end
		want = decoded_q.pop_front();
		field_check("kind", want.kind, got.kind);
		field_check("pos_x", want.pos_x, got.pos_x);
		field_check("pos_y", want.pos_y, got.pos_y);
		field_check("red", want.red, got.red);
		field_check("green", want.green, got.green);
		field_check("blue", want.blue, got.blue);
		field_check("width", want.width, got.width);
		field_check("height", want.height, got.height);
		field_check("x_offset", want.x_offset, got.x_offset);
		field_check("y_offset", want.y_offset, got.y_offset);
	endfunction

	// Input beats see the length from before the edge, so register writes come after them;
	// result beats last, all sampled at the clock edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_len = rsd_pkg::MIN_RECORD;
			phase = rsd_pkg::PH_HEADER;
			hdr_shift = '0;
			hdr_count = 0;
			rec_count = 0;
			row_idx = 0;
			row_left = 0;
			column = 0;
			run_left = 0;
			spr_w = 0;
			spr_h = 0;
			decoded_q.delete();
			outstanding <= 0;
		end else begin
			if (in_valid && !in_stall)
				decode_step(in_item);
			if (cfg_we)
				record_len = cfg_wdata;
			if (out_valid && !out_stall)
				compare_result(out_item);
			outstanding <= decoded_q.size();
		end
	end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the run-length sprite decoder: clock, reset, sprite and palette beats, verdict.
// Depends on rsd_pkg, rle_sprite_decoder_top and sprite_decode_checker.
module tb_top;

	localparam int ITEM_TARGET   = 1050;
	localparam int SETTLE_CYCLES = 8;
	localparam int QUIET_LIMIT   = 4000;
	localparam int LEN_W         = rsd_pkg::LEN_W;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	rsd_pkg::in_t     in_item = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	rsd_pkg::out_t    out_item;
	logic             cfg_we = 1'b0;
	logic [LEN_W-1:0] cfg_wdata = '0;
	int               outstanding;
	int               mismatches;
	int               tx_idle_pct = 37;
	int               rx_idle_pct = 84;
	int               beats_sent = 0;
	int               quiet_cycles = 0;
	bit               pal_written [rsd_pkg::PALETTE_DEPTH];

	rle_sprite_decoder_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	sprite_decode_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The result side stalls at random.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
	end

	// Watchdog: too long without any accepted beat ends the run.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("rle_sprite_decoder_top verification failed");
			$finish;
		end
	end

	// Offers one beat, with random gaps ahead of it, and returns at the edge that takes it.
	task automatic send_beat(input rsd_pkg::in_t beat);
		if (beats_sent < ITEM_TARGET / 3) begin
			tx_idle_pct = 37;
			rx_idle_pct = 84;
		end else if (beats_sent < 2 * ITEM_TARGET / 3) begin
			tx_idle_pct = 84;
			rx_idle_pct = 37;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= beat;
		do @(posedge clk); while (in_stall);
		beats_sent++;
	endtask

	task automatic send_palette(input logic [7:0] addr, input logic [7:0] r,
			input logic [7:0] g, input logic [7:0] b);
		rsd_pkg::in_t beat;
		beat.op = rsd_pkg::OP_PALETTE;
		beat.sprite_byte = 8'($urandom);
		beat.pal_addr = addr;
		beat.pal_red = r;
		beat.pal_green = g;
		beat.pal_blue = b;
		pal_written[addr] = 1'b1;
		send_beat(beat);
	endtask

	task automatic send_sprite_byte(input logic [7:0] v);
		rsd_pkg::in_t beat;
		beat.op = rsd_pkg::OP_SPRITE;
		beat.sprite_byte = v;
		beat.pal_addr = 8'($urandom);
		beat.pal_red = 8'($urandom);
		beat.pal_green = 8'($urandom);
		beat.pal_blue = 8'($urandom);
		send_beat(beat);
	endtask

	// Sends a record, optionally with palette writes slipped in between its bytes.
	task automatic send_record(input logic [7:0] rec[$], input bit mix);
		foreach (rec[i]) begin
			if (mix && $urandom_range(0, 15) == 0)
				send_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
			send_sprite_byte(rec[i]);
		end
	endtask

	// Lets every pending result drain, then a settling wait for bytes that give none.
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_record_len(input logic [LEN_W-1:0] v);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Pixel bytes only name palette entries that have been written.
	function automatic logic [7:0] pick_index();
		logic [7:0] idx;
		do idx = 8'($urandom); while (!pal_written[idx]);
		return idx;
	endfunction

	// Appends one byte to the end of a byte list.
	function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] v);
		q.insert(q.size(), v);
	endfunction

	function automatic void push_header(ref logic [7:0] rec[$], input logic [15:0] wf,
			input logic [15:0] hf, input logic [15:0] xo, input logic [15:0] yo);
		add_byte(rec, wf[7:0]);
		add_byte(rec, wf[15:8]);
		add_byte(rec, hf[7:0]);
		add_byte(rec, hf[15:8]);
		add_byte(rec, xo[7:0]);
		add_byte(rec, xo[15:8]);
		add_byte(rec, yo[7:0]);
		add_byte(rec, yo[15:8]);
	endfunction

	// Draws a record: mostly a well-formed sprite with random content, sometimes a bad
	// header or plain noise.
	function automatic void draw_record(ref logic [7:0] rec[$]);
		int         sel;
		int         w;
		int         h;
		int         groups;
		int         solid;
		int         cut;
		logic [15:0] wf;
		logic [15:0] hf;
		logic [7:0]  row[$];
		rec.delete();
		sel = $urandom_range(0, 99);
		if (sel < 12) begin
			repeat ($urandom_range(8, 30)) add_byte(rec, 8'($urandom));
			return;
		end
		w = ($urandom_range(0, 9) == 0) ? rsd_pkg::MAX_DIM : $urandom_range(0, 12);
		if ($urandom_range(0, 9) == 0)
			w = $urandom_range(13, rsd_pkg::MAX_DIM);
		h = $urandom_range(0, 4);
		wf = 16'(w);
		hf = 16'(h);
		if (sel < 17)
			wf = 16'h8000 | 16'($urandom);
		else if (sel < 21)
			hf = 16'h8000 | 16'($urandom);
		else if (sel < 24)
			wf = 16'($urandom_range(rsd_pkg::MAX_DIM + 1, 32767));
		else if (sel < 27)
			hf = 16'($urandom_range(rsd_pkg::MAX_DIM + 1, 32767));
		push_header(rec, wf, hf, 16'($urandom), 16'($urandom));
		if (sel < 27) begin
			repeat ($urandom_range(0, 6)) add_byte(rec, 8'($urandom));
			return;
		end
		for (int r = 0; r < h; r++) begin
			row.delete();
			groups = $urandom_range(0, 3);
			for (int g = 0; g < groups; g++) begin
				if ($urandom_range(0, 7) == 0)
					add_byte(row, 8'($urandom));
				else
					add_byte(row, 8'($urandom_range(0, (w + 2 > 255) ? 255 : w + 2)));
				solid = $urandom_range(0, 4);
				add_byte(row, 8'(solid));
				repeat (solid) add_byte(row, pick_index());
			end
			// Now and then the row count cuts a group short.
			if (row.size() > 0 && $urandom_range(0, 6) == 0) begin
				cut = $urandom_range(1, row.size());
				repeat (cut) void'(row.pop_back());
			end
			add_byte(rec, 8'(row.size()));
			foreach (row[i])
				add_byte(rec, row[i]);
		end
	endfunction

	// One length setting, then one to three records cut or padded to it, never below the header size.
	task automatic random_group();
		logic [7:0] rec[$];
		int         pick;
		int         len;
		int         span;
		int         count;
		draw_record(rec);
		pick = $urandom_range(0, 99);
		if (pick < 70)
			len = rec.size() + $urandom_range(0, 3);
		else if (pick < 92)
			len = $urandom_range(rsd_pkg::HDR_BYTES, rec.size());
		else
			len = $urandom_range(0, rsd_pkg::HDR_BYTES - 1);
		write_record_len(LEN_W'(len));
		span = (len < rsd_pkg::HDR_BYTES) ? rsd_pkg::HDR_BYTES : len;
		count = $urandom_range(1, 3);
		for (int i = 0; i < count; i++) begin
			if (i > 0)
				draw_record(rec);
			while (rec.size() < span)
				add_byte(rec, 8'($urandom));
			while (rec.size() > span)
				void'(rec.pop_back());
			send_record(rec, 1'b1);
		end
	endtask

	initial begin
		logic [7:0] rec[$];
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Two palette entries at the address extremes.
		send_palette(8'd0, 8'hFF, 8'h00, 8'h3F);
		send_palette(8'd255, 8'h00, 8'hFF, 8'hC1);

		// A width one past the limit is rejected; a length below the header size counts as one.
		write_record_len('0);
		push_header(rec, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
		send_record(rec, 1'b0);

		// Largest sprite in the longest record. The first row draws at the last column and
		// drops the next pixel; then an empty row, a zero run and a skip to the last column, and a
		// row left open in the middle of a run.
		write_record_len({LEN_W{1'b1}});
		rec.delete();
		push_header(rec, 16'd255, 16'd255, 16'h8000, 16'h7FFF);
		rec = {rec, 8'd4, 8'd254, 8'd2, 8'd255, 8'd0,
			8'd0,
			8'd5, 8'd0, 8'd0, 8'd255, 8'd1, 8'd0,
			8'd4, 8'd7, 8'd2, 8'd0};
		send_record(rec, 1'b0);

		// Shortening the record below what it has consumed closes it on the next byte,
		// here a pixel, so that beat gives a pixel and the done beat.
		write_record_len(LEN_W'(rsd_pkg::HDR_BYTES));
		send_sprite_byte(8'd255);

		// Fill the whole palette, then random records.
		for (int a = 0; a < rsd_pkg::PALETTE_DEPTH; a++)
			send_palette(8'(a), 8'($urandom), 8'($urandom), 8'($urandom));
		while (beats_sent < ITEM_TARGET)
			random_group();

		wait_idle();
		if (mismatches == 0)
			$display("rle_sprite_decoder_top verification clean");
		else
			$display("rle_sprite_decoder_top verification failed");
		$finish;
	end

endmodule

[filelist.f]
hdl/rsd_pkg.sv
hdl/rle_sprite_decoder_top.sv
tb/sv/sprite_decode_checker.sv
tb/sv/tb_top.sv
